// ----- sv/tlr_pkg.sv -----
// shared types, widths and mode codes for the thick line rasterizer
package tlr_pkg;

    localparam int COORD_BITS = 16;
    localparam int THICK_BITS = 8;
    localparam int COLOR_BITS = 32;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int MODE_BITS  = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] upos_t;
    typedef logic signed [COORD_BITS:0]   diff_t;
    typedef logic        [DELTA_BITS-1:0] delta_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic signed [ERR_BITS:0]     err2_t;
    typedef logic        [THICK_BITS-1:0] thick_t;
    typedef logic        [COLOR_BITS-1:0] color_t;
    typedef logic        [MODE_BITS-1:0]  mode_t;

    localparam mode_t MODE_IDLE  = 3'd0;
    localparam mode_t MODE_VSPAN = 3'd1;
    localparam mode_t MODE_HSPAN = 3'd2;
    localparam mode_t MODE_LEND  = 3'd3;
    localparam mode_t MODE_LWALK = 3'd4;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef struct packed {
        logic   kind;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        thick_t thickness;
        color_t color;
    } cmd_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        color_t color;
        logic   last;
    } pix_t;

endpackage

// ----- sv/tlr_cmd_reg.sv -----
// input register holding one command beat
module tlr_cmd_reg
    import tlr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd_in,
    output logic held_valid,
    output cmd_t held_cmd,
    input  logic take
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    logic accept;

    assign cmd_stall  = valid_reg && !take;
    assign accept     = cmd_valid && !cmd_stall;
    assign held_valid = valid_reg;
    assign held_cmd   = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_in;
        end
    end

endmodule

// ----- sv/tlr_engine.sv -----
// line and span stepping state with per-beat update logic
module tlr_engine
    import tlr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic held_valid,
    input  cmd_t held_cmd,
    output logic take,
    input  logic out_free,
    output logic pix_load,
    output pix_t pix_data
);

    mode_t  mode_reg,       mode_next;
    thick_t pass_index_reg, pass_index_next;
    thick_t pass_total_reg, pass_total_next;
    color_t color_reg,      color_next;
    coord_t cur_x_reg,      cur_x_next;
    coord_t cur_y_reg,      cur_y_next;
    coord_t target_x_reg,   target_x_next;
    coord_t target_y_reg,   target_y_next;
    coord_t origin_y_reg,   origin_y_next;
    coord_t line_x0_reg,    line_x0_next;
    upos_t  span_pos_reg,   span_pos_next;
    upos_t  span_base_reg,  span_base_next;
    upos_t  span_end_reg,   span_end_next;
    err_t   err_reg,        err_next;
    delta_t delta_x_reg,    delta_x_next;
    delta_t delta_y_reg,    delta_y_next;
    logic   dir_x_neg_reg,  dir_x_neg_next;
    logic   dir_y_neg_reg,  dir_y_neg_next;

    logic   emits;
    logic   step;
    logic   is_start;

    // start decode
    coord_t half;
    logic   vert;
    logic   horz;
    coord_t s0;
    coord_t s1;
    coord_t len_w;
    diff_t  st_sum;
    coord_t st_f;
    coord_t len_f;
    logic   span_ok;

    // pass setup
    diff_t  ddx;
    diff_t  ddy;
    diff_t  adx;
    diff_t  ady;

    // walk
    err2_t  e2;
    err2_t  dx_w;
    err2_t  dy_w;
    logic   step_x;
    logic   step_y;
    coord_t inc_x;
    coord_t inc_y;
    coord_t walk_x;
    coord_t walk_y;
    err_t   walk_err;

    // shared pass counting
    logic [THICK_BITS:0] pass_inc;
    logic                pass_done;
    logic [COORD_BITS:0] span_nxt;
    logic                span_wrap;

    assign is_start = (held_cmd.kind == KIND_START);
    assign emits    = !is_start && (mode_reg == MODE_VSPAN || mode_reg == MODE_HSPAN ||
                                    mode_reg == MODE_LEND || mode_reg == MODE_LWALK);
    assign take     = held_valid && (!emits || out_free);
    assign step     = take;
    assign pix_load = take && emits;

    always_comb
    begin
        half    = coord_t'(held_cmd.thickness >> 1);
        vert    = (held_cmd.start_x == held_cmd.end_x);
        horz    = (held_cmd.start_y == held_cmd.end_y);
        s0      = vert ? held_cmd.start_y : held_cmd.start_x;
        s1      = vert ? held_cmd.end_y : held_cmd.end_x;
        len_w   = s1 - s0 + coord_t'(1);
        st_sum  = diff_t'(s0) + diff_t'(len_w);
        if (len_w[COORD_BITS-1])
        begin
            st_f  = st_sum[COORD_BITS] ? coord_t'(0) : st_sum[COORD_BITS-1:0];
            len_f = -len_w;
        end
        else
        begin
            st_f  = s0;
            len_f = len_w;
        end
        span_ok = !st_f[COORD_BITS-1] && !len_f[COORD_BITS-1] && (len_f != coord_t'(0));

        ddx = diff_t'(target_x_reg) - diff_t'(line_x0_reg);
        ddy = diff_t'(target_y_reg) - diff_t'(origin_y_reg);
        adx = ddx[COORD_BITS] ? -ddx : ddx;
        ady = ddy[COORD_BITS] ? -ddy : ddy;

        e2       = err2_t'({err_reg, 1'b0});
        dx_w     = err2_t'(delta_x_reg);
        dy_w     = err2_t'(delta_y_reg);
        step_x   = (e2 > -dy_w);
        step_y   = (e2 < dx_w);
        inc_x    = dir_x_neg_reg ? coord_t'(-1) : coord_t'(1);
        inc_y    = dir_y_neg_reg ? coord_t'(-1) : coord_t'(1);
        walk_x   = step_x ? cur_x_reg + inc_x : cur_x_reg;
        walk_y   = step_y ? cur_y_reg + inc_y : cur_y_reg;
        walk_err = err_reg;
        if (step_x)
        begin
            walk_err = walk_err - err_t'(delta_y_reg);
        end
        if (step_y)
        begin
            walk_err = walk_err + err_t'(delta_x_reg);
        end

        pass_inc  = {1'b0, pass_index_reg} + {{THICK_BITS{1'b0}}, 1'b1};
        pass_done = (pass_inc >= {1'b0, pass_total_reg});
        span_nxt  = {1'b0, span_pos_reg} + {{COORD_BITS{1'b0}}, 1'b1};
        span_wrap = (span_nxt >= {1'b0, span_end_reg});
    end

    always_comb
    begin
        mode_next       = mode_reg;
        pass_index_next = pass_index_reg;
        pass_total_next = pass_total_reg;
        color_next      = color_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        target_x_next   = target_x_reg;
        target_y_next   = target_y_reg;
        origin_y_next   = origin_y_reg;
        line_x0_next    = line_x0_reg;
        span_pos_next   = span_pos_reg;
        span_base_next  = span_base_reg;
        span_end_next   = span_end_reg;
        err_next        = err_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        dir_x_neg_next  = dir_x_neg_reg;
        dir_y_neg_next  = dir_y_neg_reg;
        pix_data.x      = cur_x_reg;
        pix_data.y      = cur_y_reg;
        pix_data.color  = color_reg;
        pix_data.last   = 1'b0;

        if (step && is_start)
        begin
            pass_total_next = held_cmd.thickness;
            pass_index_next = '0;
            color_next      = held_cmd.color;
            mode_next       = MODE_IDLE;
            if (held_cmd.thickness != '0)
            begin
                if (vert || horz)
                begin
                    span_pos_next  = upos_t'(st_f);
                    span_base_next = upos_t'(st_f);
                    span_end_next  = upos_t'(st_f) + upos_t'(len_f);
                    if (vert)
                    begin
                        target_x_next = held_cmd.start_x - half;
                    end
                    else
                    begin
                        target_y_next = held_cmd.start_y - half;
                    end
                    if (span_ok)
                    begin
                        mode_next = vert ? MODE_VSPAN : MODE_HSPAN;
                    end
                end
                else
                begin
                    line_x0_next  = held_cmd.start_x - half;
                    target_x_next = held_cmd.end_x - half;
                    target_y_next = held_cmd.end_y;
                    origin_y_next = held_cmd.start_y;
                    mode_next     = MODE_LEND;
                end
            end
        end
        else if (step)
        begin
            case (mode_reg)
                MODE_VSPAN, MODE_HSPAN:
                begin
                    if (mode_reg == MODE_VSPAN)
                    begin
                        pix_data.x = target_x_reg + coord_t'(pass_index_reg);
                        pix_data.y = coord_t'(span_pos_reg);
                    end
                    else
                    begin
                        pix_data.x = coord_t'(span_pos_reg);
                        pix_data.y = target_y_reg + coord_t'(pass_index_reg);
                    end
                    span_pos_next = span_nxt[COORD_BITS-1:0];
                    if (span_wrap)
                    begin
                        span_pos_next   = span_base_reg;
                        pass_index_next = pass_inc[THICK_BITS-1:0];
                        if (pass_done)
                        begin
                            mode_next     = MODE_IDLE;
                            pix_data.last = 1'b1;
                        end
                    end
                end
                MODE_LEND:
                begin
                    pix_data.x     = target_x_reg;
                    pix_data.y     = target_y_reg;
                    dir_x_neg_next = ddx[COORD_BITS];
                    dir_y_neg_next = ddy[COORD_BITS];
                    delta_x_next   = delta_t'(adx);
                    delta_y_next   = delta_t'(ady);
                    err_next       = err_t'(adx) - err_t'(ady);
                    cur_x_next     = line_x0_reg;
                    cur_y_next     = origin_y_reg;
                    mode_next      = MODE_LWALK;
                end
                MODE_LWALK:
                begin
                    cur_x_next = walk_x;
                    cur_y_next = walk_y;
                    err_next   = walk_err;
                    if (walk_x == target_x_reg && walk_y == target_y_reg)
                    begin
                        pass_index_next = pass_inc[THICK_BITS-1:0];
                        if (pass_done)
                        begin
                            mode_next     = MODE_IDLE;
                            pix_data.last = 1'b1;
                        end
                        else
                        begin
                            line_x0_next  = line_x0_reg + coord_t'(1);
                            target_x_next = target_x_reg + coord_t'(1);
                            mode_next     = MODE_LEND;
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            pass_index_reg <= '0;
            pass_total_reg <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            pass_index_reg <= pass_index_next;
            pass_total_reg <= pass_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg     <= color_next;
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        target_x_reg  <= target_x_next;
        target_y_reg  <= target_y_next;
        origin_y_reg  <= origin_y_next;
        line_x0_reg   <= line_x0_next;
        span_pos_reg  <= span_pos_next;
        span_base_reg <= span_base_next;
        span_end_reg  <= span_end_next;
        err_reg       <= err_next;
        delta_x_reg   <= delta_x_next;
        delta_y_reg   <= delta_y_next;
        dir_x_neg_reg <= dir_x_neg_next;
        dir_y_neg_reg <= dir_y_neg_next;
    end

endmodule

// ----- sv/tlr_pix_reg.sv -----
// output register for pixel beats
module tlr_pix_reg
    import tlr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pix_load,
    input  pix_t pix_in,
    output logic out_free,
    output logic pix_valid,
    input  logic pix_stall,
    output pix_t pix_out
);

    logic valid_reg;
    logic valid_next;
    pix_t pix_reg;

    assign out_free  = !valid_reg || !pix_stall;
    assign pix_valid = valid_reg;
    assign pix_out   = pix_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (pix_load)
        begin
            valid_next = 1'b1;
        end
        else if (!pix_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_load)
        begin
            pix_reg <= pix_in;
        end
    end

endmodule

// ----- sv/thick_line_rasterizer_unit.sv -----
// top level of the thick line rasterizer
//
//   channel  handshake             payload
//   cmd      cmd_valid/cmd_stall   kind start_x start_y end_x end_y thickness color
//   pix      pix_valid/pix_stall   pixel_x pixel_y pixel_color last
//
// one command beat per cycle while no pixel stall holds the engine, set by the stepping update in the engine
// a pixel is registered in the output register when the engine takes its step beat and leaves while pix_stall is low
// reset clears the mode and the valid flags of both beat registers, so the block comes up idle
// a stalled pixel holds the engine only for step beats that give a pixel; other beats still pass
module thick_line_rasterizer_unit
    import tlr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cmd_valid,
    output logic   cmd_stall,
    input  logic   kind,
    input  coord_t start_x,
    input  coord_t start_y,
    input  coord_t end_x,
    input  coord_t end_y,
    input  thick_t thickness,
    input  color_t color,
    output logic   pix_valid,
    input  logic   pix_stall,
    output coord_t pixel_x,
    output coord_t pixel_y,
    output color_t pixel_color,
    output logic   last
);

    cmd_t cmd_in;
    cmd_t held_cmd;
    logic held_valid;
    logic take;
    logic out_free;
    logic pix_load;
    pix_t pix_data;
    pix_t pix_out;

    assign cmd_in.kind      = kind;
    assign cmd_in.start_x   = start_x;
    assign cmd_in.start_y   = start_y;
    assign cmd_in.end_x     = end_x;
    assign cmd_in.end_y     = end_y;
    assign cmd_in.thickness = thickness;
    assign cmd_in.color     = color;

    tlr_cmd_reg u_cmd_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_in     (cmd_in),
        .held_valid (held_valid),
        .held_cmd   (held_cmd),
        .take       (take)
    );

    tlr_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_cmd   (held_cmd),
        .take       (take),
        .out_free   (out_free),
        .pix_load   (pix_load),
        .pix_data   (pix_data)
    );

    tlr_pix_reg u_pix_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_load  (pix_load),
        .pix_in    (pix_data),
        .out_free  (out_free),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_out   (pix_out)
    );

    assign pixel_x     = pix_out.x;
    assign pixel_y     = pix_out.y;
    assign pixel_color = pix_out.color;
    assign last        = pix_out.last;

endmodule

// ----- bench/tlr_pixel_checker.sv -----
// pixel predictor and checker for the thick line rasterizer unit
`timescale 1ns / 100ps

module tlr_pixel_checker
    import tlr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cmd_valid,
    input  logic   cmd_stall,
    input  logic   kind,
    input  coord_t start_x,
    input  coord_t start_y,
    input  coord_t end_x,
    input  coord_t end_y,
    input  thick_t thickness,
    input  color_t color,
    input  logic   pix_valid,
    input  logic   pix_stall,
    input  coord_t pixel_x,
    input  coord_t pixel_y,
    input  color_t pixel_color,
    input  logic   last,
    output int     outstanding,
    output int     fail_count,
    output int     pixels_checked,
    output int     lines_finished
);

    localparam int MAX_REPORTS = 10;

    // working coordinates stay int: span sums run past 16 bits before they wrap
    mode_t  draw_mode;
    int     pos_x, pos_y, end_px, end_py;
    int     err, dist_x, dist_y, step_x, step_y;
    int     base, span;
    int     pass_no, pass_cnt;
    color_t ink;
    pix_t   pending_pixels[$];

    function automatic int wrap_coord(int v);
        return int'(coord_t'(v));
    endfunction

    function automatic pix_t make_pixel(int x, int y, logic fin);
        pix_t p;
        p.x     = coord_t'(x);
        p.y     = coord_t'(y);
        p.color = ink;
        p.last  = fin;
        return p;
    endfunction

    function automatic void clear_state();
        draw_mode = MODE_IDLE;
        pos_x     = 0;
        pos_y     = 0;
        end_px    = 0;
        end_py    = 0;
        err       = 0;
        dist_x    = 0;
        dist_y    = 0;
        step_x    = 0;
        step_y    = 0;
        base      = 0;
        span      = 0;
        pass_no   = 0;
        pass_cnt  = 0;
        ink       = '0;
    endfunction

    // one bresenham pass from (base, y0) to (end_px, end_py)
    function automatic void start_pass(int y0);
        int ddx, ddy;
        ddx    = end_px - base;
        ddy    = end_py - y0;
        step_x = (ddx > 0) ? 1 : ((ddx < 0) ? -1 : 0);
        step_y = (ddy > 0) ? 1 : ((ddy < 0) ? -1 : 0);
        dist_x = (ddx < 0) ? -ddx : ddx;
        dist_y = (ddy < 0) ? -ddy : ddy;
        err    = dist_x - dist_y;
        pos_x  = base;
        pos_y  = y0;
    endfunction

    function automatic void load_command(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                         thick_t th, color_t col);
        int   x0, y0, x1, y1, half, st, len;
        logic vert;
        x0        = int'(sx);
        y0        = int'(sy);
        x1        = int'(ex);
        y1        = int'(ey);
        pass_cnt  = int'(th);
        ink       = col;
        pass_no   = 0;
        draw_mode = MODE_IDLE;
        if (pass_cnt == 0)
            return;
        half = pass_cnt / 2;
        if (x0 == x1 || y0 == y1)
        begin
            vert = (x0 == x1);
            st   = vert ? y0 : x0;
            len  = vert ? wrap_coord(y1 - y0 + 1) : wrap_coord(x1 - x0 + 1);
            if (len < 0)
            begin
                st = st + len;
                if (st < 0)
                    st = 0;
                len = wrap_coord(-len);
            end
            if (st < 0 || len <= 0)
                return;
            base = st;
            span = len;
            if (vert)
            begin
                end_px    = wrap_coord(x0 - half);
                pos_y     = st;
                draw_mode = MODE_VSPAN;
            end
            else
            begin
                end_py    = wrap_coord(y0 - half);
                pos_x     = st;
                draw_mode = MODE_HSPAN;
            end
            return;
        end
        base   = wrap_coord(x0 - half);
        end_px = wrap_coord(x1 - half);
        end_py = y1;
        start_pass(y0);
        draw_mode = MODE_LEND;
    endfunction

    function automatic logic raster_step(output pix_t px);
        int   i, other, nxt, e2, y0, ox, oy;
        logic vert, fin;
        fin = 1'b0;
        px  = '0;
        case (draw_mode)
            MODE_VSPAN, MODE_HSPAN:
            begin
                vert  = (draw_mode == MODE_VSPAN);
                i     = vert ? pos_y : pos_x;
                other = (vert ? end_px : end_py) + pass_no;
                nxt   = i + 1;
                if (nxt >= base + span)
                begin
                    nxt = base;
                    pass_no++;
                    if (pass_no >= pass_cnt)
                    begin
                        draw_mode = MODE_IDLE;
                        fin       = 1'b1;
                    end
                end
                if (vert)
                begin
                    px    = make_pixel(other, i, fin);
                    pos_y = nxt;
                end
                else
                begin
                    px    = make_pixel(i, other, fin);
                    pos_x = nxt;
                end
                return 1'b1;
            end
            MODE_LEND:
            begin
                px        = make_pixel(end_px, end_py, 1'b0);
                draw_mode = MODE_LWALK;
                return 1'b1;
            end
            MODE_LWALK:
            begin
                e2 = err * 2;
                ox = pos_x;
                oy = pos_y;
                if (e2 > -dist_y)
                begin
                    err   = err - dist_y;
                    pos_x = wrap_coord(pos_x + step_x);
                end
                if (e2 < dist_x)
                begin
                    err   = err + dist_x;
                    pos_y = wrap_coord(pos_y + step_y);
                end
                if (pos_x == end_px && pos_y == end_py)
                begin
                    pass_no++;
                    if (pass_no >= pass_cnt)
                    begin
                        draw_mode = MODE_IDLE;
                        fin       = 1'b1;
                    end
                    else
                    begin
                        y0     = end_py - step_y * dist_y;
                        base   = wrap_coord(base + 1);
                        end_px = wrap_coord(end_px + 1);
                        start_pass(y0);
                        draw_mode = MODE_LEND;
                    end
                end
                px = make_pixel(ox, oy, fin);
                return 1'b1;
            end
            default:
                draw_mode = MODE_IDLE;
        endcase
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pix_t want;
        logic has_pixel;
        if (!rst_n)
        begin
            clear_state();
            pending_pixels.delete();
            outstanding <= 0;
        end
        else
        begin
            if (pix_valid && !pix_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected pixel: x=%0d y=%0d color=%h last=%b",
                                 pixel_x, pixel_y, pixel_color, last);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    if (want.last)
                        lines_finished++;
                    if (pixel_x !== want.x || pixel_y !== want.y ||
                        pixel_color !== want.color || last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("pixel %0d: expected x=%0d y=%0d color=%h last=%b",
                                     pixels_checked, want.x, want.y, want.color, want.last);
                            $display("pixel %0d: got      x=%0d y=%0d color=%h last=%b",
                                     pixels_checked, pixel_x, pixel_y, pixel_color, last);
                        end
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                if (kind == KIND_START)
                    load_command(start_x, start_y, end_x, end_y, thickness, color);
                else
                begin
                    has_pixel = raster_step(want);
                    if (has_pixel)
                        pending_pixels.push_back(want);
                end
            end
            outstanding <= pending_pixels.size();
        end
    end

endmodule

// ----- bench/thick_line_rasterizer_unit_tb.sv -----
// testbench top for the thick line rasterizer unit: stimulus, idling and verdict
`timescale 1ns / 100ps

module thick_line_rasterizer_unit_tb;
    import tlr_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int ITEM_TARGET    = 1250;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 8;

    logic   clk;
    logic   rst_n;
    logic   cmd_valid;
    logic   cmd_stall;
    logic   kind;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    thick_t thickness;
    color_t color;
    logic   pix_valid;
    logic   pix_stall;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last;

    int     outstanding;
    int     fail_count;
    int     pixels_checked;
    int     lines_finished;

    logic   hold_req;
    logic   hold_done;
    int     burst_left;
    int     gap_max;
    int     starts_sent;
    int     steps_sent;

    thick_line_rasterizer_unit i_dut
    (
        .clk, .rst_n,
        .cmd_valid, .cmd_stall, .kind, .start_x, .start_y, .end_x, .end_y,
        .thickness, .color,
        .pix_valid, .pix_stall, .pixel_x, .pixel_y, .pixel_color, .last
    );

    tlr_pixel_checker i_checker
    (
        .clk, .rst_n,
        .cmd_valid, .cmd_stall, .kind, .start_x, .start_y, .end_x, .end_y,
        .thickness, .color,
        .pix_valid, .pix_stall, .pixel_x, .pixel_y, .pixel_color, .last,
        .outstanding, .fail_count, .pixels_checked, .lines_finished
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic coord_t near(coord_t c);
        return coord_t'(int'(c) + int'($urandom_range(0, 12)) - 6);
    endfunction

    function automatic int pixel_estimate(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                          thick_t th);
        int dx, dy;
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        return int'(th) * ((dx > dy ? dx : dy) + 1);
    endfunction

    task automatic send_beat(input logic k, input coord_t sx, sy, ex, ey,
                             input thick_t th, input color_t col);
        int gap;
        cmd_valid <= 1'b1;
        kind      <= k;
        start_x   <= sx;
        start_y   <= sy;
        end_x     <= ex;
        end_y     <= ey;
        thickness <= th;
        color     <= col;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (k == KIND_START)
            starts_sent++;
        else
            steps_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            if (gap_max > 0)
            begin
                gap = $urandom_range(1, gap_max);
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic step_beats(input int n);
        repeat (n)
            send_beat(KIND_STEP, coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom), thick_t'($urandom), $urandom);
    endtask

    task automatic draw(input coord_t sx, sy, ex, ey, input thick_t th,
                        input color_t col, input int n);
        send_beat(KIND_START, sx, sy, ex, ey, th, col);
        step_beats(n);
    endtask

    task automatic drain_pixels();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic random_command();
        coord_t sx, sy, ex, ey;
        thick_t th;
        int     shape, est, n, d;
        shape = $urandom_range(0, 9);
        sx    = ($urandom_range(0, 3) == 0) ? near(coord_t'(0)) : coord_t'($urandom);
        sy    = ($urandom_range(0, 3) == 0) ? near(coord_t'(0)) : coord_t'($urandom);
        if (shape >= 8)
        begin
            ex = coord_t'($urandom);
            ey = coord_t'($urandom);
            th = thick_t'($urandom);
            n  = $urandom_range(0, 6);
        end
        else
        begin
            ex = near(sx);
            ey = near(sy);
            if (shape < 2)
                ex = sx;
            else if (shape < 4)
                ey = sy;
            else if (shape == 4)
            begin
                d  = $urandom_range(1, 6);
                ex = coord_t'(int'(sx) + d);
                ey = coord_t'(int'(sy) - d);
            end
            th = ($urandom_range(0, 11) == 0) ? thick_t'(0) : thick_t'($urandom_range(1, 5));
            if ($urandom_range(0, 15) == 0)
                th = thick_t'($urandom_range(6, 12));
            est = pixel_estimate(sx, sy, ex, ey, th);
            if (est > 200)
                est = 200;
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, est)
                                            : est + $urandom_range(0, 2);
        end
        draw(sx, sy, ex, ey, th, $urandom, n);
    endtask

    // pixel side: stall phases of random style, plus one long hold on request
    initial
    begin : pixel_sink
        int style, phase_len;
        hold_done = 1'b0;
        pix_stall <= 1'b0;
        forever
        begin
            style     = $urandom_range(0, 2);
            phase_len = $urandom_range(10, 120);
            repeat (phase_len)
            begin
                @(posedge clk);
                if (hold_req && !hold_done)
                begin
                    pix_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_done = 1'b1;
                    pix_stall <= 1'b0;
                end
                else if (style == 0)
                    pix_stall <= 1'b0;
                else if (style == 1)
                    pix_stall <= ($urandom_range(0, 3) == 0);
                else
                    pix_stall <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (pix_valid && !pix_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic pressure_done;
        pressure_done = 1'b0;
        hold_req      = 1'b0;
        burst_left    = 0;
        gap_max       = 0;
        starts_sent   = 0;
        steps_sent    = 0;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        kind      <= KIND_START;
        start_x   <= '0;
        start_y   <= '0;
        end_x     <= '0;
        end_y     <= '0;
        thickness <= '0;
        color     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases
        // step while idle
        step_beats(1);
        // zero thickness
        draw(16'sd10, 16'sd10, 16'sd20, 16'sd20, 8'd0, 32'h0000_0000, 2);
        // vertical span
        draw(16'sd3, 16'sd2, 16'sd3, 16'sd4, 8'd2, 32'h1234_5678, 7);
        // reversed row span
        draw(16'sd5, 16'sd7, 16'sd2, 16'sd7, 8'd1, 32'hffff_ffff, 4);
        // negative span start
        draw(-16'sd5, 16'sd1, -16'sd2, 16'sd1, 8'd1, 32'h0000_0001, 2);
        // most negative length
        draw(16'sd4, 16'sh7fff, 16'sd4, -16'sd2, 8'd1, 32'h0000_0002, 2);
        // column offset wraps
        draw(16'sh8000, 16'sd0, 16'sh8000, 16'sd1, 8'd3, 32'h0000_0003, 7);
        // row span at top edge
        draw(16'sh7ffe, 16'sd100, 16'sh7fff, 16'sd100, 8'd2, 32'h0000_0004, 5);
        // shallow line
        draw(16'sd0, 16'sd0, 16'sd2, 16'sd1, 8'd3, 32'h0000_0005, 10);
        // steep line
        draw(16'sd0, 16'sd0, 16'sd1, -16'sd3, 8'd1, 32'h0000_0006, 5);
        // extremes, replaced
        draw(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 8'd255, 32'haaaa_5555, 4);
        // pass shift wraps
        draw(16'sh8000, 16'sd5, 16'sh8002, 16'sd7, 8'd4, 32'h0000_0007, 4);
        drain_pixels();

        while (starts_sent + steps_sent < ITEM_TARGET)
        begin
            if (!pressure_done && starts_sent + steps_sent >= ITEM_TARGET / 3)
            begin
                pressure_done = 1'b1;
                drain_pixels();
                hold_req = 1'b1;
                gap_max  = 0;
                draw(16'sd0, 16'sd0, 16'sd100, 16'sd37, 8'd2, $urandom, 120);
            end
            if ($urandom_range(0, 5) == 0)
                gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            random_command();
        end
        drain_pixels();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d start beats and %0d step beats, with a long pixel hold",
                 starts_sent, steps_sent);
        $display("%0d pixels compared, %0d commands drawn to their last pixel",
                 pixels_checked, lines_finished);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
